// ----- rtl/core/assert_macros.svh -----
// Assertion helper macros for the chunked body decoder RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/cbd_pkg.sv -----
// Shared types, codes and helpers for the chunked body decoder.
// No dependencies.
`default_nettype none

package cbd_pkg;

  typedef enum logic [5:0] {
    PH_SIZE  = 6'b000001,
    PH_DATA  = 6'b000010,
    PH_SKIP  = 6'b000100,
    PH_DONE  = 6'b001000,
    PH_BAD   = 6'b010000,
    PH_ERROR = 6'b100000
  } phase_t;

  typedef logic [2:0] kind_t;

  localparam kind_t KIND_FRAME     = 3'd0;
  localparam kind_t KIND_BODY      = 3'd1;
  localparam kind_t KIND_COMPLETE  = 3'd2;
  localparam kind_t KIND_MALFORMED = 3'd3;
  localparam kind_t KIND_IGNORED   = 3'd4;

  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_SEMI = 8'h3B;
  localparam logic [7:0] CHAR_SP   = 8'h20;
  localparam logic [7:0] CHAR_TAB  = 8'h09;

  localparam logic [1:0] SKIP_COUNT = 2'd2;

  // size line flags
  typedef struct packed {
    logic digit_seen;
    logic blank_after_digit;
    logic in_extension;
    logic cr_pending;
  } line_flags_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t       h;
    logic [7:0] d;
    h = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      h.ok = 1'b1;
      h.val = d[3:0];
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      h.ok = 1'b1;
      h.val = d[3:0];
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      h.ok = 1'b1;
      h.val = d[3:0];
    end else begin
      d = '0;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/cbd_in_if.sv -----
// Input channel: raw body bytes with a restart flag, valid/ready handshake.
// No dependencies.
`default_nettype none

interface cbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       new_body;

  modport source (output valid, output data_byte, output new_body, input ready);
  modport sink   (input valid, input data_byte, input new_body, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/cbd_out_if.sv -----
// Output channel: one decode result per request, valid/ready handshake.
// No dependencies.
`default_nettype none

interface cbd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] out_kind;
  logic [7:0] out_byte;

  modport source (output valid, output out_kind, output out_byte, input ready);
  modport sink   (input valid, input out_kind, input out_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/cbd_step.sv -----
// Next-state and result logic for one byte of the chunked body decoder.
// Depends on cbd_pkg.
`default_nettype none

module cbd_step #(
  parameter int SIZE_BITS = 32
) (
  input  wire logic [7:0]           data_byte,
  input  wire logic                 new_body,
  input  wire cbd_pkg::phase_t      phase,
  input  wire logic [SIZE_BITS-1:0] size_accum,
  input  wire logic [SIZE_BITS-1:0] bytes_left,
  input  wire logic [1:0]           skip_left,
  input  wire cbd_pkg::line_flags_t flags,
  output cbd_pkg::phase_t           phase_next,
  output logic [SIZE_BITS-1:0]      size_accum_next,
  output logic [SIZE_BITS-1:0]      bytes_left_next,
  output logic [1:0]                skip_left_next,
  output cbd_pkg::line_flags_t      flags_next,
  output cbd_pkg::kind_t            out_kind,
  output logic [7:0]                out_byte
);
  import cbd_pkg::*;

  phase_t               ph;
  logic [SIZE_BITS-1:0] acc;
  logic [SIZE_BITS-1:0] left;
  logic [1:0]           skip;
  line_flags_t          fl;
  hex_t                 hex;
  logic                 ovf;

  assign hex = hex_decode(data_byte);

  always_comb begin
    // restart clears everything before this byte is taken
    ph   = phase;
    acc  = size_accum;
    left = bytes_left;
    skip = skip_left;
    fl   = flags;
    if (new_body) begin
      ph   = PH_SIZE;
      acc  = '0;
      left = '0;
      skip = '0;
      fl   = '0;
    end
    ovf = (acc[SIZE_BITS-1 -: 4] != 4'd0);

    phase_next      = ph;
    size_accum_next = acc;
    bytes_left_next = left;
    skip_left_next  = skip;
    flags_next      = fl;
    out_kind        = KIND_FRAME;
    out_byte        = '0;

    unique case (ph)
      PH_SIZE: begin
        if (data_byte == CHAR_LF) begin
          if (!fl.digit_seen) begin
            phase_next = PH_ERROR;
            out_kind   = KIND_MALFORMED;
          end else if (acc == '0) begin
            phase_next = PH_DONE;
            out_kind   = KIND_COMPLETE;
          end else begin
            bytes_left_next = acc;
            phase_next      = PH_DATA;
          end
          size_accum_next = '0;
          flags_next      = '0;
        end else if (fl.in_extension) begin
          phase_next = PH_SIZE;
        end else if (fl.cr_pending) begin
          phase_next = PH_BAD;
        end else if (data_byte == CHAR_SEMI) begin
          flags_next.in_extension = 1'b1;
        end else if (data_byte == CHAR_CR) begin
          flags_next.cr_pending = 1'b1;
        end else if (data_byte == CHAR_SP || data_byte == CHAR_TAB) begin
          if (fl.digit_seen) begin
            flags_next.blank_after_digit = 1'b1;
          end
        end else if (!hex.ok || fl.blank_after_digit || ovf) begin
          phase_next = PH_BAD;
        end else begin
          size_accum_next       = {acc[SIZE_BITS-5:0], hex.val};
          flags_next.digit_seen = 1'b1;
        end
      end
      PH_DATA: begin
        out_kind        = KIND_BODY;
        out_byte        = data_byte;
        bytes_left_next = left - SIZE_BITS'(1);
        if (bytes_left_next == '0) begin
          phase_next     = PH_SKIP;
          skip_left_next = SKIP_COUNT;
        end
      end
      PH_SKIP: begin
        skip_left_next = skip - 2'd1;
        if (skip_left_next == 2'd0) begin
          phase_next      = PH_SIZE;
          size_accum_next = '0;
          flags_next      = '0;
        end
      end
      PH_BAD: begin
        if (data_byte == CHAR_LF) begin
          out_kind        = KIND_MALFORMED;
          phase_next      = PH_ERROR;
          size_accum_next = '0;
          flags_next      = '0;
        end
      end
      default: begin
        out_kind = KIND_IGNORED;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/chunked_body_decoder_top.sv -----
// Top level of the chunked body decoder: input register, step logic, result register.
// Depends on cbd_pkg, cbd_in_if, cbd_out_if, cbd_step and assert_macros.svh.
`default_nettype none

// Channel   Dir  Payload                       Notes
// in_ch     in   data_byte[7:0], new_body      one raw body byte per request
// out_ch    out  out_kind[2:0], out_byte[7:0]  exactly one result per request
//
// A request in the input register is decoded by cbd_step; its result enters the result
// register when that is free or drained. Throughput is one byte per cycle while out_ch
// does not stall, since cbd_step needs only one shift-add or decrement per byte.
// rst is synchronous: phase goes to size line start, counters and flags clear.
// A stalled result holds in the output register while the input register
// still takes one more request; only then does in_ch.ready drop.
module chunked_body_decoder_top #(
  parameter int SIZE_BITS = 32
) (
  input wire logic clk,
  input wire logic rst,
  cbd_in_if.sink   in_ch,
  cbd_out_if.source out_ch
);
  import cbd_pkg::*;

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_new_body;
  logic       s1_advance;

  // decoder state
  phase_t               phase;
  logic [SIZE_BITS-1:0] size_accum;
  logic [SIZE_BITS-1:0] bytes_left;
  logic [1:0]           skip_left;
  line_flags_t          flags;

  phase_t               phase_next;
  logic [SIZE_BITS-1:0] size_accum_next;
  logic [SIZE_BITS-1:0] bytes_left_next;
  logic [1:0]           skip_left_next;
  line_flags_t          flags_next;
  kind_t                kind_next;
  logic [7:0]           byte_next;

  // result register
  logic       o_valid;
  kind_t      o_kind;
  logic [7:0] o_byte;

  // the input stage moves on when the result register is free or being drained
  assign s1_advance = s1_valid && (!o_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte     <= in_ch.data_byte;
      s1_new_body <= in_ch.new_body;
    end
  end

  cbd_step #(
    .SIZE_BITS (SIZE_BITS)
  ) u_step (
    .data_byte       (s1_byte),
    .new_body        (s1_new_body),
    .phase           (phase),
    .size_accum      (size_accum),
    .bytes_left      (bytes_left),
    .skip_left       (skip_left),
    .flags           (flags),
    .phase_next      (phase_next),
    .size_accum_next (size_accum_next),
    .bytes_left_next (bytes_left_next),
    .skip_left_next  (skip_left_next),
    .flags_next      (flags_next),
    .out_kind        (kind_next),
    .out_byte        (byte_next)
  );

  // state commits only when the byte's result enters the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_SIZE;
      size_accum <= '0;
      bytes_left <= '0;
      skip_left  <= '0;
      flags      <= '0;
    end else if (s1_advance) begin
      phase      <= phase_next;
      size_accum <= size_accum_next;
      bytes_left <= bytes_left_next;
      skip_left  <= skip_left_next;
      flags      <= flags_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s1_advance) begin
      o_valid <= 1'b1;
    end else if (out_ch.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      o_kind <= kind_next;
      o_byte <= byte_next;
    end
  end

  assign out_ch.valid    = o_valid;
  assign out_ch.out_kind = o_kind;
  assign out_ch.out_byte = o_byte;

  `include "assert_macros.svh"

  `ASSERT_CLK(a_data_has_bytes, clk, rst,
    (phase == PH_DATA) |-> (bytes_left != '0), "data phase with no bytes left")
  `ASSERT_CLK(a_skip_has_count, clk, rst,
    (phase == PH_SKIP) |-> (skip_left != 2'd0), "skip phase with zero count")
  `ASSERT_CLK(a_s1_holds, clk, rst,
    (s1_valid && !s1_advance) |=> (s1_valid && $stable(s1_byte) && $stable(s1_new_body)),
    "input register lost a stalled request")
  `ASSERT_CLK(a_byte_only_body, clk, rst,
    (o_valid && o_kind != KIND_BODY) |-> (o_byte == 8'd0), "nonzero byte on a non-body result")
  `ASSERT_ALWAYS(a_reset_phase, clk,
    $past(rst) |-> (phase == PH_SIZE && !o_valid && !s1_valid), "reset did not clear control state")

endmodule

`default_nettype wire
